[rtl/qfta_pkg.sv]
// Shared types and constants for the queue feedback and token admission block.
package qfta_pkg;

  localparam int unsigned QW    = 24;  // occupancy and threshold width
  localparam int unsigned SW    = 14;  // packet size and MTU width
  localparam int unsigned RATEW = 12;  // supply rate width
  localparam int unsigned TW    = 48;  // timestamp width
  localparam int unsigned DTW   = 36;  // clamped elapsed time width
  localparam int unsigned PRODW = RATEW + DTW;
  localparam int unsigned SUPW  = 34;  // clamped supply width
  localparam int unsigned BALW  = 35;  // signed balance before saturation
  localparam int unsigned TOKW  = 32;  // supply token balance
  localparam int unsigned FETW  = 16;  // flow-end token counter

  localparam logic [QW-1:0]    MaxQueueRst = 24'd1048576;
  localparam logic [QW-1:0]    FbThreshRst = 24'd1500;
  localparam logic [SW-1:0]    MtuRst      = 14'd1500;
  localparam logic [RATEW-1:0] RateRst     = 12'd200;

  // Any supply of this size or more saturates the balance at the MTU cap.
  localparam logic [SUPW-1:0]  SupplyCap   = {1'b1, {(SUPW-1){1'b0}}};
  localparam logic [TOKW-1:0]  TokMin      = {1'b1, {(TOKW-1){1'b0}}};

  localparam logic REQ_ARRIVE = 1'b0;
  localparam logic REQ_DEPART = 1'b1;

  typedef enum logic [1:0] {
    CFG_MAX_QUEUE = 2'd0,
    CFG_FB_THRESH = 2'd1,
    CFG_MTU       = 2'd2,
    CFG_RATE      = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic          req_type;
    logic [SW-1:0] pkt_bytes;
    logic          is_data;
    logic          feedback_already_sent;
    logic          last_of_flow;
    logic          first_window;
    logic          wants_increase;
    logic [TW-1:0] now_ns;
  } in_beat_t;

  typedef struct packed {
    logic          dropped;
    logic          send_feedback;
    logic [QW-1:0] feedback_queue_bytes;
    logic          increase_granted;
    logic [QW-1:0] queue_bytes_now;
  } out_beat_t;

endpackage

[rtl/qfta_supply.sv]
// Supply earned since a reference time: rate * elapsed / 16, clamped.
module qfta_supply (
  input  logic [qfta_pkg::TW-1:0]    now_i,
  input  logic [qfta_pkg::TW-1:0]    last_i,
  input  logic [qfta_pkg::RATEW-1:0] rate_i,
  output logic [qfta_pkg::SUPW-1:0]  supply_o
);

  logic [qfta_pkg::TW-1:0]    dt_full;
  logic [qfta_pkg::DTW-1:0]   dt;
  logic [qfta_pkg::PRODW-1:0] prod;
  logic [qfta_pkg::PRODW-5:0] sup_raw;

  // Elapsed time wraps modulo 2^48; gaps of 2^36 or more clamp to the 36-bit maximum.
  assign dt_full = now_i - last_i;
  assign dt      = (|dt_full[qfta_pkg::TW-1:qfta_pkg::DTW]) ? '1
                                                             : dt_full[qfta_pkg::DTW-1:0];
  assign prod    = qfta_pkg::PRODW'(rate_i) * qfta_pkg::PRODW'(dt);
  assign sup_raw = prod[qfta_pkg::PRODW-1:4];

  assign supply_o = (sup_raw > (qfta_pkg::PRODW-4)'(qfta_pkg::SupplyCap))
                    ? qfta_pkg::SupplyCap : sup_raw[qfta_pkg::SUPW-1:0];

endmodule

[rtl/queue_feedback_token_admission.sv]
// Top level: egress queue occupancy, congestion feedback and increase-token admission.

// Takes one arrival or departure beat per cycle while the output is not stalled and
// returns one result beat for each, registered in turn in stage 1, stage 2 and the
// output register. The first stage computes the supply earned since the previous data
// arrival for both possible predecessors (the committed timestamp and the item one stage
// ahead), each with its own 12x36 multiplier; the second stage picks one and
// updates occupancy, the token balances and the last data time together, which sets
// the one-beat-per-cycle rate. Configuration registers are written through
// cfg_we_i/cfg_idx_i/cfg_wdata_i and must only change while no beat is in flight.
module queue_feedback_token_admission (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  qfta_pkg::in_beat_t    in_beat_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output qfta_pkg::out_beat_t   out_beat_o,
  input  logic                  cfg_we_i,
  input  qfta_pkg::cfg_idx_e    cfg_idx_i,
  input  logic [qfta_pkg::QW-1:0] cfg_wdata_i
);

  // configuration
  logic [qfta_pkg::QW-1:0]    max_q, thr_q;
  logic [qfta_pkg::SW-1:0]    mtu_q;
  logic [qfta_pkg::RATEW-1:0] rate_q;

  // block state
  logic [qfta_pkg::QW-1:0]          occ_q, occ_d;
  logic [qfta_pkg::FETW-1:0]        fet_q, fet_d;
  logic signed [qfta_pkg::TOKW-1:0] st_q, st_d;
  logic [qfta_pkg::TW-1:0]          last_q, last_d;

  // pipeline
  logic                       s1_vld_q, s2_vld_q, out_vld_q;
  qfta_pkg::in_beat_t         s1_q, s2_q;
  logic [qfta_pkg::SUPW-1:0]  s2_sup_last_q, s2_sup_prev_q;
  logic                       s2_use_prev_q;
  qfta_pkg::out_beat_t        out_q, res;
  logic [qfta_pkg::SUPW-1:0]  sup_last, sup_prev, supply;
  logic                       in_fire, s1_adv, s2_adv;

  // commit stage
  logic                             is_dep, drop, acc_data, fb, earn, want;
  logic                             spend_fet, spend_sup, refuse, fet_zero, bal_fit;
  logic [qfta_pkg::QW:0]            occ_sum;
  logic signed [qfta_pkg::BALW-1:0] bal, mtu_bal;
  logic signed [qfta_pkg::TOKW-1:0] tok, mtu_tok;

  assign s2_adv     = s2_vld_q && (!out_vld_q || out_ready_i);
  assign s1_adv     = s1_vld_q && (!s2_vld_q || s2_adv);
  assign in_ready_o = !s1_vld_q || s1_adv;
  assign in_fire    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q  <= qfta_pkg::MaxQueueRst;
      thr_q  <= qfta_pkg::FbThreshRst;
      mtu_q  <= qfta_pkg::MtuRst;
      rate_q <= qfta_pkg::RateRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        qfta_pkg::CFG_MAX_QUEUE: max_q  <= cfg_wdata_i;
        qfta_pkg::CFG_FB_THRESH: thr_q  <= cfg_wdata_i;
        qfta_pkg::CFG_MTU:       mtu_q  <= cfg_wdata_i[qfta_pkg::SW-1:0];
        qfta_pkg::CFG_RATE:      rate_q <= cfg_wdata_i[qfta_pkg::RATEW-1:0];
        default: ;
      endcase
    end
  end

  // Supply for the beat in stage 1, against either predecessor timestamp.
  qfta_supply u_sup_last (
    .now_i    (s1_q.now_ns),
    .last_i   (last_q),
    .rate_i   (rate_q),
    .supply_o (sup_last)
  );

  qfta_supply u_sup_prev (
    .now_i    (s1_q.now_ns),
    .last_i   (s2_q.now_ns),
    .rate_i   (rate_q),
    .supply_o (sup_prev)
  );

  always_comb begin
    is_dep   = (s2_q.req_type == qfta_pkg::REQ_DEPART);
    occ_sum  = {1'b0, occ_q} + (qfta_pkg::QW+1)'(s2_q.pkt_bytes);
    drop     = !is_dep && (occ_sum > {1'b0, max_q});
    acc_data = !is_dep && !drop && s2_q.is_data;
    supply   = s2_use_prev_q ? s2_sup_prev_q : s2_sup_last_q;

    mtu_bal  = $signed({{(qfta_pkg::BALW-qfta_pkg::SW){1'b0}}, mtu_q});
    mtu_tok  = $signed({{(qfta_pkg::TOKW-qfta_pkg::SW){1'b0}}, mtu_q});
    bal      = $signed({1'b0, supply})
             + $signed({{(qfta_pkg::BALW-qfta_pkg::TOKW){st_q[qfta_pkg::TOKW-1]}}, st_q})
             - $signed({{(qfta_pkg::BALW-qfta_pkg::SW){1'b0}}, s2_q.pkt_bytes});
    bal_fit  = (bal[qfta_pkg::BALW-1:qfta_pkg::TOKW-1] == '0) ||
               (bal[qfta_pkg::BALW-1:qfta_pkg::TOKW-1] == '1);
    // cap at the MTU, saturate low at the 32-bit minimum
    if (bal > mtu_bal) begin
      tok = mtu_tok;
    end else if (!bal_fit) begin
      tok = $signed(qfta_pkg::TokMin);
    end else begin
      tok = bal[qfta_pkg::TOKW-1:0];
    end

    fet_zero  = (fet_q == '0);
    fb        = acc_data && !s2_q.feedback_already_sent && (occ_q > thr_q);
    earn      = acc_data && !fb && s2_q.last_of_flow && !s2_q.first_window;
    want      = acc_data && !fb && !earn && s2_q.wants_increase;
    spend_fet = want && !fet_zero;
    spend_sup = want && fet_zero && (tok >= mtu_tok);
    refuse    = want && fet_zero && !spend_sup;

    if (is_dep) begin
      occ_d = (occ_q >= qfta_pkg::QW'(s2_q.pkt_bytes))
              ? occ_q - qfta_pkg::QW'(s2_q.pkt_bytes) : '0;
    end else if (!drop) begin
      occ_d = occ_sum[qfta_pkg::QW-1:0];
    end else begin
      occ_d = occ_q;
    end

    fet_d = fet_q;
    if (earn && (fet_q != '1)) begin
      fet_d = fet_q + qfta_pkg::FETW'(1);
    end else if (spend_fet) begin
      fet_d = fet_q - qfta_pkg::FETW'(1);
    end

    // Balance never exceeds the MTU after refresh, so a spend leaves it at zero.
    st_d   = acc_data ? (spend_sup ? '0 : tok) : st_q;
    last_d = acc_data ? s2_q.now_ns : last_q;

    res.dropped              = drop;
    res.send_feedback        = fb;
    res.feedback_queue_bytes = fb ? occ_q : '0;
    res.increase_granted     = !is_dep && !drop && s2_q.wants_increase && !refuse;
    res.queue_bytes_now      = occ_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q      <= 1'b0;
      s2_vld_q      <= 1'b0;
      out_vld_q     <= 1'b0;
      s2_use_prev_q <= 1'b0;
      occ_q         <= '0;
      fet_q         <= '0;
      st_q          <= '0;
      last_q        <= '0;
    end else begin
      if (in_fire) begin
        s1_vld_q <= 1'b1;
      end else if (s1_adv) begin
        s1_vld_q <= 1'b0;
      end
      if (s1_adv) begin
        s2_vld_q      <= 1'b1;
        s2_use_prev_q <= s2_adv && acc_data;
      end else if (s2_adv) begin
        s2_vld_q <= 1'b0;
      end
      if (s2_adv) begin
        out_vld_q <= 1'b1;
        occ_q     <= occ_d;
        fet_q     <= fet_d;
        st_q      <= st_d;
        last_q    <= last_d;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_q <= in_beat_i;
    end
    if (s1_adv) begin
      s2_q          <= s1_q;
      s2_sup_last_q <= sup_last;
      s2_sup_prev_q <= sup_prev;
    end
    if (s2_adv) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_beat_o  = out_q;

  a_drop_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> !(out_q.dropped && (out_q.send_feedback || out_q.increase_granted)))
    else $error("dropped beat carries feedback or grant");

  a_fbq_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !out_q.send_feedback |-> out_q.feedback_queue_bytes == '0)
    else $error("feedback occupancy without feedback");

  a_s2_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_vld_q && !s2_adv |=> s2_vld_q && $stable(s2_q))
    else $error("commit stage lost a stalled beat");

  a_fb_tokens: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_adv && fb |=> fet_q == $past(fet_q))
    else $error("flow-end tokens changed on a feedback beat");

endmodule
